### hw/rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions for the Playfair digraph encryptor
// Letter codes, square geometry, item kinds, controller states and the
// result record that the output buffer holds.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ALPHABET   = 26;

  localparam int LETTER_W = 5;
  localparam int COORD_W  = 3;
  localparam int POS_W    = 2 * COORD_W;
  localparam int CELL_W   = 5;

  localparam logic [LETTER_W-1:0] CODE_A = LETTER_W'(0);
  localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
  localparam logic [LETTER_W-1:0] CODE_X = LETTER_W'(23);
  localparam logic [LETTER_W-1:0] CODE_LAST = LETTER_W'(ALPHABET - 1);

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_PLAIN  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_GRID,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_letter;
    logic                pair_last;
    logic                message_end;
  } out_item_t;

endpackage

### hw/rtl/playfair_digraph_encryptor.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor: Playfair cipher on a 5x5 key square
// Builds the key square from a stream of key letters and encrypts
// plaintext letters pairwise into a stream of ciphertext letters.
// ----------------------------------------------------------------------------
// Items arrive on the slave stream with the kind in tuser, the letter in
// tdata and the end-of-message flag in tlast. Begin, key letters and first
// letters of a pair are taken at once; the letter that closes a pair needs a
// read of the position memory (both letters through its two read ports), a
// read of the square memory (both cipher cells) and a load of the two results
// into the output buffer, which waits until the buffer has drained. A finish
// item walks the alphabet one letter at a time, bounded by the single write
// port of the two memories. Neither memory is cleared: the taken marks
// (flip-flops) qualify position reads and the fill count qualifies square
// reads, so no clearing pass runs after reset or begin.
module playfair_digraph_encryptor
  import pfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [4:0] letter, [7:5] zero
  input  logic [1:0] s_axis_tuser_i,   // [1:0] kind
  input  logic       s_axis_tlast_i,   // last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [4:0] cipher_letter, [7:5] zero
  output logic       m_axis_tuser_o,   // [0] pair_last
  output logic       m_axis_tlast_o    // message_end
);

  state_e state_q, state_d;

  // Memories: key square (cell -> letter) and letter positions (row, column).
  logic [LETTER_W-1:0] grid_mem [GRID_CELLS];
  logic [POS_W-1:0]    pos_mem  [ALPHABET];

  logic [ALPHABET-1:0] taken_q, taken_d;
  logic [CELL_W-1:0]   fill_cnt_q, fill_cnt_d;
  logic [COORD_W-1:0]  fill_row_q, fill_row_d;
  logic [COORD_W-1:0]  fill_col_q, fill_col_d;
  logic [LETTER_W-1:0] held_letter_q, held_letter_d;
  logic                held_valid_q, held_valid_d;
  logic [LETTER_W-1:0] walk_q, walk_d;
  logic                last_q;

  logic [POS_W-1:0]    pos_a_q, pos_b_q;
  logic                taken_a_q, taken_b_q;
  logic [LETTER_W-1:0] grid_a_q, grid_b_q;
  logic                cell_ok_a_q, cell_ok_b_q;

  out_item_t out_ent0_q, out_ent1_q;
  logic [1:0] out_cnt_q;

  logic                in_fire, out_fire;
  kind_e               in_kind;
  logic [LETTER_W-1:0] in_letter, in_folded;
  logic                in_letter_ok;

  logic                place_en;
  logic [LETTER_W-1:0] place_letter;
  logic                pos_rd_en, grid_rd_en, out_load;
  logic [LETTER_W-1:0] rd_addr_a, rd_addr_b;
  logic [CELL_W-1:0]   grid_idx_a, grid_idx_b;

  logic [COORD_W-1:0]  r1, c1, r2, c2;
  logic [COORD_W-1:0]  ra, ca, rb, cb;
  logic [LETTER_W-1:0] cipher_a, cipher_b;

  function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] v);
    return (v == COORD_W'(GRID_SIDE - 1)) ? '0 : v + COORD_W'(1);
  endfunction

  assign in_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire     = m_axis_tvalid_o && m_axis_tready_i;
  assign in_kind      = kind_e'(s_axis_tuser_i);
  assign in_letter    = s_axis_tdata_i[LETTER_W-1:0];
  assign in_letter_ok = in_letter <= CODE_LAST;
  assign in_folded    = (in_letter == CODE_J) ? CODE_I : in_letter;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_FINISH) begin
            state_d = ST_FILL;
          end else if (in_kind == KIND_PLAIN && in_letter_ok &&
                       (held_valid_q || s_axis_tlast_i)) begin
            state_d = ST_POS;
          end
        end
      end
      ST_POS:  state_d = ST_GRID;
      ST_GRID: if (out_cnt_q == 2'd0) state_d = ST_IDLE;
      ST_FILL: if (walk_q == CODE_LAST) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Pair geometry: positions of letters that are not in the square read as
  // row 0, column 0.
  always_comb begin
    r1 = taken_a_q ? pos_a_q[POS_W-1:COORD_W] : '0;
    c1 = taken_a_q ? pos_a_q[COORD_W-1:0]     : '0;
    r2 = taken_b_q ? pos_b_q[POS_W-1:COORD_W] : '0;
    c2 = taken_b_q ? pos_b_q[COORD_W-1:0]     : '0;
    if (r1 == r2) begin
      ra = r1; ca = wrap_inc(c1);
      rb = r2; cb = wrap_inc(c2);
    end else if (c1 == c2) begin
      ra = wrap_inc(r1); ca = c1;
      rb = wrap_inc(r2); cb = c2;
    end else begin
      ra = r1; ca = c2;
      rb = r2; cb = c1;
    end
    grid_idx_a = CELL_W'(ra) * CELL_W'(GRID_SIDE) + CELL_W'(ca);
    grid_idx_b = CELL_W'(rb) * CELL_W'(GRID_SIDE) + CELL_W'(cb);
    // Cells not yet filled read as letter A.
    cipher_a = cell_ok_a_q ? grid_a_q : CODE_A;
    cipher_b = cell_ok_b_q ? grid_b_q : CODE_A;
  end

  // Control outputs and state updates.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    taken_d       = taken_q;
    fill_cnt_d    = fill_cnt_q;
    fill_row_d    = fill_row_q;
    fill_col_d    = fill_col_q;
    held_letter_d = held_letter_q;
    held_valid_d  = held_valid_q;
    walk_d        = walk_q;
    place_en      = 1'b0;
    place_letter  = in_folded;
    pos_rd_en     = 1'b0;
    grid_rd_en    = 1'b0;
    out_load      = 1'b0;
    rd_addr_a     = held_valid_q ? held_letter_q : in_folded;
    rd_addr_b     = held_valid_q ? in_folded : CODE_X;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_BEGIN: begin
              taken_d      = '0;
              fill_cnt_d   = '0;
              fill_row_d   = '0;
              fill_col_d   = '0;
              held_valid_d = 1'b0;
            end
            KIND_KEY: begin
              place_en = in_letter_ok;
            end
            KIND_FINISH: begin
              walk_d = '0;
            end
            KIND_PLAIN: begin
              if (in_letter_ok) begin
                if (held_valid_q || s_axis_tlast_i) begin
                  pos_rd_en    = 1'b1;
                  held_valid_d = 1'b0;
                end else begin
                  held_letter_d = in_folded;
                  held_valid_d  = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_POS: begin
        grid_rd_en = 1'b1;
      end
      ST_GRID: begin
        out_load = (out_cnt_q == 2'd0);
      end
      ST_FILL: begin
        place_letter = walk_q;
        place_en     = (walk_q != CODE_J);
        walk_d       = walk_q + LETTER_W'(1);
      end
      default: ;
    endcase

    // A letter goes into the next free cell unless it is taken or the square is full.
    if (place_en && !taken_q[place_letter] && fill_cnt_q < CELL_W'(GRID_CELLS)) begin
      taken_d[place_letter] = 1'b1;
      fill_cnt_d = fill_cnt_q + CELL_W'(1);
      if (fill_col_q == COORD_W'(GRID_SIDE - 1)) begin
        fill_col_d = '0;
        fill_row_d = fill_row_q + COORD_W'(1);
      end else begin
        fill_col_d = fill_col_q + COORD_W'(1);
      end
    end else begin
      place_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      taken_q      <= '0;
      fill_cnt_q   <= '0;
      fill_row_q   <= '0;
      fill_col_q   <= '0;
      held_valid_q <= 1'b0;
      walk_q       <= '0;
    end else begin
      state_q      <= state_d;
      taken_q      <= taken_d;
      fill_cnt_q   <= fill_cnt_d;
      fill_row_q   <= fill_row_d;
      fill_col_q   <= fill_col_d;
      held_valid_q <= held_valid_d;
      walk_q       <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_letter_q <= held_letter_d;
    if (pos_rd_en) begin
      last_q <= s_axis_tlast_i;
    end
  end

  // Memory write port, shared by key placement and the finish walk.
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      grid_mem[fill_cnt_q]  <= place_letter;
      pos_mem[place_letter] <= {fill_row_q, fill_col_q};
    end
  end

  // Position memory: two registered read ports.
  always_ff @(posedge clk_i) begin
    if (pos_rd_en) begin
      pos_a_q   <= pos_mem[rd_addr_a];
      pos_b_q   <= pos_mem[rd_addr_b];
      taken_a_q <= taken_q[rd_addr_a];
      taken_b_q <= taken_q[rd_addr_b];
    end
  end

  // Square memory: two registered read ports.
  always_ff @(posedge clk_i) begin
    if (grid_rd_en) begin
      grid_a_q    <= grid_mem[grid_idx_a];
      grid_b_q    <= grid_mem[grid_idx_b];
      cell_ok_a_q <= grid_idx_a < fill_cnt_q;
      cell_ok_b_q <= grid_idx_b < fill_cnt_q;
    end
  end

  // Two-entry output buffer; it is loaded only when empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (out_load) begin
      out_cnt_q <= 2'd2;
    end else if (out_fire) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ent0_q <= '{cipher_letter: cipher_a, pair_last: 1'b0, message_end: 1'b0};
      out_ent1_q <= '{cipher_letter: cipher_b, pair_last: 1'b1, message_end: last_q};
    end else if (out_fire) begin
      out_ent0_q <= out_ent1_q;
    end
  end

  assign m_axis_tvalid_o = (out_cnt_q != 2'd0);
  assign m_axis_tdata_o  = {3'b000, out_ent0_q.cipher_letter};
  assign m_axis_tuser_o  = out_ent0_q.pair_last;
  assign m_axis_tlast_o  = out_ent0_q.message_end;

  // The fill count and the row and column of the next free cell agree.
  a_fill_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q == CELL_W'(fill_row_q) * CELL_W'(GRID_SIDE) + CELL_W'(fill_col_q))
    else $error("fill count and fill coordinates disagree");

  // The end of a message is only ever flagged on the second letter of a pair.
  a_end_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("message end on a first letter");

  // A finished pair with an empty buffer yields exactly two results.
  a_pair_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GRID && out_cnt_q == 2'd0 |=> out_cnt_q == 2'd2 && state_q == ST_IDLE)
    else $error("pair results not loaded");

  // No first letter remains held while a pair is being encrypted.
  a_held_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POS |-> !held_valid_q && $past(held_valid_q || s_axis_tlast_i))
    else $error("held letter survives a pair");

endmodule
